[rtl/matrix_shortest_path_query_defines.svh]
// Assertion shorthands used by the RTL.
`ifndef MATRIX_SHORTEST_PATH_QUERY_DEFINES_SVH
`define MATRIX_SHORTEST_PATH_QUERY_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MSPQ_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MSPQ_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/mspq_pkg.sv]
package mspq_pkg;

   localparam int MAX_NODES   = 128;
   localparam int NODE_BITS   = $clog2(MAX_NODES);
   localparam int PAIR_BITS   = 2 * NODE_BITS;
   localparam int WEIGHT_BITS = 16;
   localparam int DIST_BITS   = 24;
   localparam int COUNT_BITS  = 8;

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_ADD   = 2'd1,
      REQ_QUERY = 2'd2
   } req_code_type;

   // One matrix entry: presence plus both weights.
   typedef struct packed {
      logic                   present;
      logic [WEIGHT_BITS-1:0] wt_time;
      logic [WEIGHT_BITS-1:0] wt_cost;
   } edge_ent_type;

   // One distance scratch entry.
   typedef struct packed {
      logic                 reached;
      logic [DIST_BITS-1:0] dval;
   } dist_ent_type;

   typedef struct packed {
      logic                 en;
      logic [NODE_BITS-1:0] addr;
      dist_ent_type         data;
   } dist_wr_type;

   // Saturating distance + weight.
   function automatic logic [DIST_BITS-1:0] sat_add(input logic [DIST_BITS-1:0] d,
                                                    input logic [WEIGHT_BITS-1:0] w);
      logic [DIST_BITS:0] s;
      s = {1'b0, d} + (DIST_BITS + 1)'(w);
      return s[DIST_BITS] ? {DIST_BITS{1'b1}} : s[DIST_BITS-1:0];
   endfunction

endpackage

[rtl/mspq_dist_ram.sv]
module mspq_dist_ram (
   input  logic                              clock,
   input  mspq_pkg::dist_wr_type             wr,
   input  logic [mspq_pkg::NODE_BITS-1:0]    rd_addr,
   output mspq_pkg::dist_ent_type            rd_data
);
   import mspq_pkg::*;

   dist_ent_type mem [MAX_NODES];
   dist_ent_type rdq_ff;
   dist_ent_type fwd_data_ff;
   logic         fwd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rdq_ff      <= mem[rd_addr];
      // read during write to the same entry returns the new data
      fwd_hit_ff  <= wr.en && (wr.addr == rd_addr);
      fwd_data_ff <= wr.data;
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rdq_ff;

endmodule

[rtl/matrix_shortest_path_query.sv]
// Shortest-path query engine over an undirected weighted graph.
//
// req channel (req_tvalid/req_tready): one transaction per command, kind in req_tuser:
//   clear graph, add edge (both directions, repeated pair overwrites), or query.
// rsp channel: one transaction per query: distance in rsp_tdata, reachable in rsp_tuser.
// csr channel (csr_valid/csr_ready, always ready): writes node_count; write it only idle.
//
// Work per command, from the accepting cycle:
//   add edge : one matrix write per direction, forward then mirrored
//   clear    : accept, then a clearing pass over every matrix entry, one per cycle
//   query    : initialize the distance entry of each of the n nodes (n = effective
//              node count), then n-1 rounds over all rows, each reached row scanning
//              its n entries; then read the destination entry and answer.
//              Out-of-range endpoints skip the walk and answer unreachable, distance 0.
// One command is in flight at a time; the next is taken once it finishes, even while
// a query result still waits in the output register. A query finishing while that
// register is still full holds in its last cycle until it drains.
// Reset starts a clearing pass over every matrix entry with req_tready low; csr writes are
// still taken. A stalled rsp holds its data; a finished query waits until it drains.
`include "matrix_shortest_path_query_defines.svh"

module matrix_shortest_path_query (
   input  logic        clock,
   input  logic        reset,
   // request: node_a[6:0], node_b[13:7], edge_cost[29:14], edge_time[45:30], zero pad
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // req_type[1:0], use_time[2]
   input  logic [2:0]  req_tuser,
   // response: distance[23:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   // reachable[0]
   output logic        rsp_tuser,
   // node_count write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [mspq_pkg::COUNT_BITS-1:0] csr_data
);
   import mspq_pkg::*;

   typedef enum logic [9:0] {
      S_SWEEP  = 10'b0000000001,
      S_IDLE   = 10'b0000000010,
      S_EDGE2  = 10'b0000000100,
      S_INIT   = 10'b0000001000,
      S_ROWRD  = 10'b0000010000,
      S_ROWCHK = 10'b0000100000,
      S_SCAN   = 10'b0001000000,
      S_FINRD  = 10'b0010000000,
      S_FINCHK = 10'b0100000000,
      S_DONE   = 10'b1000000000
   } state_type;

   // request fields
   req_code_type           req_code;
   logic [NODE_BITS-1:0]   req_a;
   logic [NODE_BITS-1:0]   req_b;
   logic [WEIGHT_BITS-1:0] req_cost;
   logic [WEIGHT_BITS-1:0] req_time;
   logic                   req_use_time;
   logic                   req_fire;

   assign req_code     = req_code_type'(req_tuser[1:0]);
   assign req_use_time = req_tuser[2];
   assign req_a        = req_tdata[6:0];
   assign req_b        = req_tdata[13:7];
   assign req_cost     = req_tdata[29:14];
   assign req_time     = req_tdata[45:30];

   state_type              state_ff, state_in;
   logic [PAIR_BITS-1:0]   sweep_cnt_ff, sweep_cnt_in;
   logic [NODE_BITS-1:0]   j_ff, j_in;
   logic [NODE_BITS-1:0]   k_ff, k_in;
   logic [NODE_BITS-1:0]   r_ff, r_in;
   logic [NODE_BITS-1:0]   n_last_ff, n_last_in;
   logic [NODE_BITS-1:0]   src_ff, src_in;
   logic [NODE_BITS-1:0]   dst_ff, dst_in;
   logic                   use_time_ff, use_time_in;
   logic [WEIGHT_BITS-1:0] cost_ff, cost_in;
   logic [WEIGHT_BITS-1:0] time_ff, time_in;
   logic [DIST_BITS-1:0]   dj_ff, dj_in;
   logic                   p_vld_ff, p_vld_in;
   logic [NODE_BITS-1:0]   p_k_ff, p_k_in;
   dist_ent_type           res_ff, res_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   dist_ent_type           rsp_ff, rsp_in;
   logic [COUNT_BITS-1:0]  node_count_ff, node_count_in;

   // matrix memory
   edge_ent_type           emem [2**PAIR_BITS];
   edge_ent_type           erd_ff;
   logic                   em_we;
   logic [PAIR_BITS-1:0]   em_waddr;
   edge_ent_type           em_wdata;
   logic [PAIR_BITS-1:0]   em_raddr;

   // distance scratch
   dist_wr_type            dist_wr;
   logic [NODE_BITS-1:0]   d_raddr;
   dist_ent_type           drd;

   // relax evaluation
   logic [WEIGHT_BITS-1:0] ev_w;
   logic [DIST_BITS-1:0]   ev_cand;
   logic [NODE_BITS-1:0]   eff_last;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_ff.dval;
   assign rsp_tuser  = rsp_ff.reached;

   // last usable node index, count clamped to 1..MAX_NODES
   always_comb begin
      if (node_count_ff == '0) begin
         eff_last = '0;
      end else if (node_count_ff > COUNT_BITS'(MAX_NODES)) begin
         eff_last = NODE_BITS'(MAX_NODES - 1);
      end else begin
         eff_last = NODE_BITS'(node_count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (em_we) begin
         emem[em_waddr] <= em_wdata;
      end
      erd_ff <= emem[em_raddr];
   end

   assign em_raddr = {j_ff, k_ff};

   mspq_dist_ram u_dist (
      .clock   (clock),
      .wr      (dist_wr),
      .rd_addr (d_raddr),
      .rd_data (drd)
   );

   assign ev_w    = use_time_ff ? erd_ff.wt_time : erd_ff.wt_cost;
   assign ev_cand = sat_add(dj_ff, ev_w);

   always_comb begin
      state_in      = state_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      r_in          = r_ff;
      n_last_in     = n_last_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      use_time_in   = use_time_ff;
      cost_in       = cost_ff;
      time_in       = time_ff;
      dj_in         = dj_ff;
      p_vld_in      = 1'b0;
      p_k_in        = p_k_ff;
      res_in        = res_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_in        = rsp_ff;
      node_count_in = csr_valid ? csr_data : node_count_ff;
      em_we         = 1'b0;
      em_waddr      = {src_ff, dst_ff};
      em_wdata      = '0;
      d_raddr       = k_ff;
      dist_wr       = '0;

      // write-back stage of the relax pipe: entry k from the previous scan step
      if (p_vld_ff && erd_ff.present) begin
         if (!drd.reached || (ev_cand < drd.dval)) begin
            dist_wr.en           = 1'b1;
            dist_wr.addr         = p_k_ff;
            dist_wr.data.reached = 1'b1;
            dist_wr.data.dval    = ev_cand;
         end
      end

      case (state_ff)
         S_SWEEP: begin
            em_we        = 1'b1;
            em_waddr     = sweep_cnt_ff;
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (sweep_cnt_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               case (req_code)
                  REQ_CLEAR: begin
                     sweep_cnt_in = '0;
                     state_in     = S_SWEEP;
                  end
                  REQ_ADD: begin
                     em_we    = 1'b1;
                     em_waddr = {req_a, req_b};
                     em_wdata = '{present: 1'b1, wt_time: req_time, wt_cost: req_cost};
                     src_in   = req_b;
                     dst_in   = req_a;
                     cost_in  = req_cost;
                     time_in  = req_time;
                     state_in = S_EDGE2;
                  end
                  REQ_QUERY: begin
                     src_in      = req_a;
                     dst_in      = req_b;
                     use_time_in = req_use_time;
                     n_last_in   = eff_last;
                     j_in        = '0;
                     if ((req_a > eff_last) || (req_b > eff_last)) begin
                        res_in   = '0;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_INIT;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_EDGE2: begin
            // mirrored entry; endpoints were stored swapped
            em_we    = 1'b1;
            em_waddr = {src_ff, dst_ff};
            em_wdata = '{present: 1'b1, wt_time: time_ff, wt_cost: cost_ff};
            state_in = S_IDLE;
         end
         S_INIT: begin
            dist_wr.en           = 1'b1;
            dist_wr.addr         = j_ff;
            dist_wr.data.reached = (j_ff == src_ff);
            dist_wr.data.dval    = '0;
            if (j_ff == n_last_ff) begin
               j_in     = '0;
               r_in     = '0;
               state_in = (n_last_ff == '0) ? S_FINRD : S_ROWRD;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_ROWRD: begin
            d_raddr  = j_ff;
            state_in = S_ROWCHK;
         end
         S_ROWCHK, S_SCAN: begin
            if ((state_ff == S_ROWCHK) && drd.reached) begin
               dj_in    = drd.dval;
               k_in     = '0;
               state_in = S_SCAN;
            end else begin
               if (state_ff == S_SCAN) begin
                  d_raddr  = k_ff;
                  p_vld_in = 1'b1;
                  p_k_in   = k_ff;
               end
               if ((state_ff == S_SCAN) && (k_ff != n_last_ff)) begin
                  k_in = k_ff + 1'b1;
               end else if (j_ff != n_last_ff) begin
                  // next row of this round
                  j_in     = j_ff + 1'b1;
                  state_in = S_ROWRD;
               end else begin
                  j_in = '0;
                  if (NODE_BITS'(r_ff + 1'b1) == n_last_ff) begin
                     state_in = S_FINRD;
                  end else begin
                     r_in     = r_ff + 1'b1;
                     state_in = S_ROWRD;
                  end
               end
            end
         end
         S_FINRD: begin
            d_raddr  = dst_ff;
            state_in = S_FINCHK;
         end
         S_FINCHK: begin
            res_in.reached = drd.reached;
            res_in.dval    = drd.reached ? drd.dval : '0;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_in        = res_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         sweep_cnt_ff  <= '0;
         j_ff          <= '0;
         k_ff          <= '0;
         r_ff          <= '0;
         n_last_ff     <= '0;
         p_vld_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         node_count_ff <= COUNT_BITS'(MAX_NODES);
      end else begin
         state_ff      <= state_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         j_ff          <= j_in;
         k_ff          <= k_in;
         r_ff          <= r_in;
         n_last_ff     <= n_last_in;
         p_vld_ff      <= p_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         node_count_ff <= node_count_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      use_time_ff <= use_time_in;
      cost_ff     <= cost_in;
      time_ff     <= time_in;
      dj_ff       <= dj_in;
      p_k_ff      <= p_k_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   // distance writes stay inside the active node range
   `MSPQ_ASSERT_IMP(a_dist_wr_range, dist_wr.en, dist_wr.addr <= n_last_ff, "dist write out of range")
   // outside init, a distance update comes only from a relaxed present edge
   `MSPQ_ASSERT_IMP(a_relax_src, dist_wr.en && (state_ff != S_INIT), p_vld_ff && erd_ff.present, "dist write without relax")
   // the clearing pass ends after the last matrix entry
   `MSPQ_ASSERT_NXT(a_sweep_end, (state_ff == S_SWEEP) && (sweep_cnt_ff == '1), state_ff == S_IDLE, "sweep overrun")

endmodule

[sim/tb.sv]
module tb;
   import mspq_pkg::*;

   localparam logic [1:0]  REQ_UNUSED      = 2'd3;     // spare code, block drops it
   localparam int          CLEAR_CYCLES    = 16384;    // one pass over the matrix
   localparam int          SETTLE_CYCLES   = 16;
   localparam int          RSP_HOLD_CYCLES = 40000;    // outlasts a clear, then queries pile up
   localparam int          CYCLE_LIMIT     = 20000000;
   localparam int          PHASES          = 6;        // per idling mode
   localparam int          PHASE_ITEMS     = 31;
   localparam logic [24:0] DIST_CEIL       = 25'hFFFFFF;

   typedef struct packed {
      logic [DIST_BITS-1:0] distance;
      logic                 reachable;
   } route_answer_type;

   // One row of the directed script. A count write, when flagged, goes in
   // before the row's transaction.
   typedef struct packed {
      logic                   set_count;
      logic [COUNT_BITS-1:0]  count_val;
      logic [1:0]             kind;
      logic [NODE_BITS-1:0]   node_a;
      logic [NODE_BITS-1:0]   node_b;
      logic [WEIGHT_BITS-1:0] edge_cost;
      logic [WEIGHT_BITS-1:0] edge_time;
      logic                   use_time;
      logic                   known;
      logic [DIST_BITS-1:0]   known_dist;
      logic                   known_reach;
   } script_row_type;

   localparam int SCRIPT_ROWS = 23;
   localparam script_row_type DIRECTED_ROWS [SCRIPT_ROWS] = '{
      // full-size graph, empty: same source and destination
      '{1, 128, REQ_QUERY,   5,   5,      0,      0, 0, 1,     0, 1},
      '{0,   0, REQ_ADD,     0, 127, 16'hFFFF,    1, 0, 0,     0, 0},
      '{0,   0, REQ_QUERY, 127,   0,      0,      0, 1, 1,     1, 1},
      // count 0 clamps to one node
      '{1,   0, REQ_QUERY,   0,   0,      0,      0, 0, 1,     0, 1},
      '{0,   0, REQ_QUERY,   0,   1,      0,      0, 0, 1,     0, 0},
      // count above the node limit clamps to the limit
      '{1, 255, REQ_QUERY,   0, 127,      0,      0, 0, 1, 65535, 1},
      // four nodes: max weights, self loop, overwrite in reverse order
      '{1,   4, REQ_ADD,     1,   2, 16'hFFFF, 16'hFFFF, 0, 0,  0, 0},
      '{0,   0, REQ_ADD,     2,   3, 16'hFFFF, 16'hFFFF, 1, 0,  0, 0},
      '{0,   0, REQ_ADD,     3,   3,      0,      0, 0, 0,     0, 0},
      '{0,   0, REQ_ADD,     2,   1,     10,     20, 0, 0,     0, 0},
      '{0,   0, REQ_QUERY,   1,   3,      0,      0, 0, 1, 65545, 1},
      '{0,   0, REQ_QUERY,   3,   1,      0,      0, 1, 1, 65555, 1},
      '{0,   0, REQ_QUERY,   0,   3,      0,      0, 0, 1,     0, 0},
      '{0,   0, REQ_QUERY,   1,   4,      0,      0, 0, 1,     0, 0},
      // endpoint beyond the count is stored but not walked
      '{0,   0, REQ_ADD,   100,   1,      1,      1, 0, 0,     0, 0},
      '{0,   0, REQ_ADD,     0,   3,      5,      7, 1, 0,     0, 0},
      '{0,   0, REQ_QUERY,   0,   2,      0,      0, 0, 0,     0, 0},
      '{0,   0, REQ_QUERY,   2,   0, 16'hFFFF, 16'hFFFF, 1, 0,  0, 0},
      '{0,   0, REQ_UNUSED,127, 127, 16'hFFFF, 16'hFFFF, 1, 0,  0, 0},
      '{0,   0, REQ_CLEAR, 127,   0, 16'hFFFF,      0, 1, 0,     0, 0},
      '{0,   0, REQ_QUERY,   1,   2,      0,      0, 0, 1,     0, 0},
      '{0,   0, REQ_ADD,     3,   3, 16'hFFFF, 16'hFFFF, 0, 0,  0, 0},
      '{0,   0, REQ_QUERY,   3,   3,      0,      0, 1, 1,     0, 1}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [47:0]           req_tdata = '0;   // node_a, node_b, edge_cost, edge_time, pad
   logic [2:0]            req_tuser = '0;   // req_type, use_time
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;        // distance
   logic                  rsp_tuser;        // reachable
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [COUNT_BITS-1:0] csr_data = '0;

   // Mirror of the graph and the count register.
   logic [WEIGHT_BITS-1:0] cost_w [MAX_NODES*MAX_NODES];
   logic [WEIGHT_BITS-1:0] time_w [MAX_NODES*MAX_NODES];
   bit                     edge_on [MAX_NODES*MAX_NODES];
   logic [COUNT_BITS-1:0]  node_count_q = 8'd128;

   route_answer_type awaited_answers [$];
   int unsigned   err_count     = 0;
   int unsigned   items_sent    = 0;
   int unsigned   answers_seen  = 0;
   int unsigned   count_writes  = 0;
   int unsigned   cycle_count   = 0;
   int unsigned   send_idle_pct = 0;
   int unsigned   recv_idle_pct = 0;
   bit            last_was_clear = 1'b0;
   bit            hold_start     = 1'b0;

   matrix_shortest_path_query uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Bellman-Ford over the mirrored matrix. Relaxes only out of reached nodes
   // and only along present edges; sums clip at the 24-bit ceiling.
   function automatic route_answer_type answer_query(input logic [NODE_BITS-1:0] src,
                                                     input logic [NODE_BITS-1:0] dst,
                                                     input logic by_time);
      route_answer_type     ans;
      int unsigned          n, r, j, k, idx;
      logic [DIST_BITS-1:0] best [MAX_NODES];
      bit                   reached [MAX_NODES];
      logic [24:0]          cand;
      logic [WEIGHT_BITS-1:0] w;
      ans = '0;
      n = (node_count_q == 0) ? 1 : (node_count_q > MAX_NODES) ? MAX_NODES : node_count_q;
      if (src >= n || dst >= n) return ans;
      for (j = 0; j < n; j++) begin
         best[j] = '0;
         reached[j] = 1'b0;
      end
      reached[src] = 1'b1;
      for (r = 1; r < n; r++) begin
         for (j = 0; j < n; j++) begin
            if (!reached[j]) continue;
            for (k = 0; k < n; k++) begin
               idx = j * MAX_NODES + k;
               if (!edge_on[idx]) continue;
               w = by_time ? time_w[idx] : cost_w[idx];
               cand = {1'b0, best[j]} + 25'(w);
               if (cand > DIST_CEIL) cand = DIST_CEIL;
               if (!reached[k] || cand[DIST_BITS-1:0] < best[k]) begin
                  best[k] = cand[DIST_BITS-1:0];
                  reached[k] = 1'b1;
               end
            end
         end
      end
      if (reached[dst]) begin
         ans.distance  = best[dst];
         ans.reachable = 1'b1;
      end
      return ans;
   endfunction

   function automatic logic [NODE_BITS-1:0] pick_node(input int unsigned n);
      if ($urandom_range(0, 9) == 0) return NODE_BITS'($urandom_range(0, MAX_NODES - 1));
      return NODE_BITS'($urandom_range(0, n - 1));
   endfunction

   // Small weights make competing routes tie or cross; wide ones hit the top bits.
   function automatic logic [WEIGHT_BITS-1:0] pick_weight();
      if ($urandom_range(0, 1) == 0) return WEIGHT_BITS'($urandom_range(0, 20));
      return WEIGHT_BITS'($urandom_range(0, 65535));
   endfunction

   // Offer one request transaction; on acceptance update the mirror and queue
   // the answer. Leaves tvalid high: a caller that pauses lowers it at once.
   task automatic issue(input logic [1:0] kind,
                        input logic [NODE_BITS-1:0] a, input logic [NODE_BITS-1:0] b,
                        input logic [WEIGHT_BITS-1:0] c, input logic [WEIGHT_BITS-1:0] t,
                        input logic ut, input bit known, input route_answer_type known_ans);
      int unsigned ab, ba;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, t, c, b, a};
      req_tuser  <= {ut, kind};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      last_was_clear = (kind == REQ_CLEAR);
      ab = a * MAX_NODES + b;
      ba = b * MAX_NODES + a;
      case (kind)
         REQ_CLEAR: begin
            foreach (edge_on[i]) edge_on[i] = 1'b0;
         end
         REQ_ADD: begin
            // 7-bit endpoints always fit the matrix, both directions written
            cost_w[ab] = c;
            cost_w[ba] = c;
            time_w[ab] = t;
            time_w[ba] = t;
            edge_on[ab] = 1'b1;
            edge_on[ba] = 1'b1;
         end
         REQ_QUERY: begin
            awaited_answers.push_back(known ? known_ans : answer_query(a, b, ut));
         end
         default: ;
      endcase
   endtask

   // Drain all answers, then give a trailing clear time to finish.
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (last_was_clear ? CLEAR_CYCLES + SETTLE_CYCLES : SETTLE_CYCLES)
         @(posedge clock);
   endtask

   task automatic set_node_count(input logic [COUNT_BITS-1:0] value);
      wait_until_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      node_count_q = value;
      count_writes++;
   endtask

   // Response side: check each transaction against the oldest expectation and
   // randomize tready, with one long hold-off on request.
   initial begin : rsp_side
      int unsigned      hold_left;
      route_answer_type want;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (awaited_answers.size() == 0) begin
               $error("unexpected result: distance %0d reachable %0d", rsp_tdata, rsp_tuser);
               err_count++;
            end else begin
               want = awaited_answers.pop_front();
               answers_seen++;
               if (rsp_tdata !== want.distance) begin
                  $error("distance: expected %0d, got %0d", want.distance, rsp_tdata);
                  err_count++;
               end
               if (rsp_tuser !== want.reachable) begin
                  $error("reachable: expected %0d, got %0d", want.reachable, rsp_tuser);
                  err_count++;
               end
            end
         end
         if (hold_start) begin
            hold_left  = RSP_HOLD_CYCLES;
            hold_start = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      script_row_type        row;
      int unsigned           mode, phase, k, n, pick;
      logic [COUNT_BITS-1:0] count_pick;
      foreach (edge_on[i]) edge_on[i] = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Sender idles lightly, receiver heavily, for the script and mode 0.
      send_idle_pct = 34;
      recv_idle_pct = 82;
      for (k = 0; k < SCRIPT_ROWS; k++) begin
         row = DIRECTED_ROWS[k];
         if (row.set_count) set_node_count(row.count_val);
         issue(row.kind, row.node_a, row.node_b, row.edge_cost, row.edge_time,
               row.use_time, row.known, {row.known_dist, row.known_reach});
      end

      // Random phases: small graphs built up and queried in a random mix, with some noise.
      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_idle_pct = 34; recv_idle_pct = 82; end
            1: begin send_idle_pct = 82; recv_idle_pct = 34; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (phase = 0; phase < PHASES; phase++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) count_pick = 8'd1;
            else if (pick <= 2) count_pick = COUNT_BITS'($urandom_range(11, 16));
            else count_pick = COUNT_BITS'($urandom_range(2, 10));
            set_node_count(count_pick);
            n = count_pick;
            // back-pressure: answers pile up and the block stalls its input
            if (mode == 2 && phase == 0) hold_start = 1'b1;
            if ($urandom_range(0, 2) == 0)
               issue(REQ_CLEAR, pick_node(MAX_NODES), pick_node(MAX_NODES),
                     pick_weight(), pick_weight(), 1'($urandom_range(0, 1)), 1'b0, '0);
            for (k = 0; k < PHASE_ITEMS; k++) begin
               pick = $urandom_range(0, 99);
               if (pick < 5)
                  issue(REQ_UNUSED, pick_node(MAX_NODES), pick_node(MAX_NODES),
                        WEIGHT_BITS'($urandom_range(0, 65535)),
                        WEIGHT_BITS'($urandom_range(0, 65535)),
                        1'($urandom_range(0, 1)), 1'b0, '0);
               else if (pick < 50)
                  issue(REQ_ADD, pick_node(n), pick_node(n), pick_weight(), pick_weight(),
                        1'($urandom_range(0, 1)), 1'b0, '0);
               else
                  issue(REQ_QUERY, pick_node(n), pick_node(n), pick_weight(), pick_weight(),
                        1'($urandom_range(0, 1)), 1'b0, '0);
            end
         end
      end

      wait_until_idle();
      $display("Sent %0d request transactions, checked %0d answers, %0d count writes.",
               items_sent, answers_seen, count_writes);
      $display("Covered count clamping, self loops, overwrites, unreachable and out-of-range ends.");
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[matrix_shortest_path_query.f]
+incdir+rtl
rtl/mspq_pkg.sv
rtl/mspq_dist_ram.sv
rtl/matrix_shortest_path_query.sv
sim/tb.sv
